[rtl/dpb_pkg.sv]
package dpb_pkg;

  localparam int DEPTH_W   = 16;
  localparam int PIX_W     = 12;
  localparam int CENTER_W  = 16;
  localparam int INV_W     = 25;
  localparam int COORD_W   = 32;
  localparam int DIFF_W    = 16;
  localparam int PROD1_W   = DIFF_W + DEPTH_W;
  localparam int PROD2_W   = PROD1_W + INV_W;
  localparam int FRAC_BITS = 24;
  localparam int MAG_W     = PROD2_W + 1 - FRAC_BITS;
  localparam int LANES     = 2;

  localparam int IMAGE_WIDTH_DEF  = 1280;
  localparam int IMAGE_HEIGHT_DEF = 720;
  localparam int DIM_W            = PIX_W + 1;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 1;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [DEPTH_W-1:0]  NEAR_RST  = 16'd500;
  localparam logic [DEPTH_W-1:0]  FAR_RST   = 16'd1200;
  localparam logic [CENTER_W-1:0] CCOL_RST  = 16'd10232;
  localparam logic [CENTER_W-1:0] CROW_RST  = 16'd5824;
  localparam logic [INV_W-1:0]    INVX_RST  = 25'd26194;
  localparam logic [INV_W-1:0]    INVY_RST  = 25'd26194;

  typedef enum logic [2:0] {
    REG_NEAR  = 3'd0,
    REG_FAR   = 3'd1,
    REG_CCOL  = 3'd2,
    REG_CROW  = 3'd3,
    REG_INVX  = 3'd4,
    REG_INVY  = 3'd5
  } cfg_reg_t;

endpackage

[rtl/depth_pixel_backprojection.sv]
// Back-projects one depth pixel per clock, unless the output stalls, to a
// 3-D point through a pinhole model. A transaction can be accepted every
// cycle while m_tready keeps the pipeline moving; the result passes through
// five register stages (offset, depth product, reciprocal product,
// rounding, saturation). Each stage holds while the stage after it is full
// and stalled, so bubbles are squeezed out under backpressure.
// Input tdata: depth_mm [15:0], pixel_col [27:16], pixel_row [39:28].
// Output tdata: point_x [31:0], point_y [63:32], point_z [79:64]; tuser
// holds point_valid. A point is valid when near < depth < far and the pixel
// lies inside the image; otherwise x, y and z read zero. Registers (APB,
// byte address 4*i): near_limit, far_limit, center_col_q4, center_row_q4,
// inv_focal_x_q24, inv_focal_y_q24; write them only while the pipeline is
// empty.
module depth_pixel_backprojection #(
  parameter int IMAGE_WIDTH  = dpb_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = dpb_pkg::IMAGE_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dpb_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [dpb_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [dpb_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // depth_mm, pixel_col, pixel_row
  input  logic [dpb_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // point_x, point_y, point_z
  output logic [dpb_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // point_valid
  output logic [dpb_pkg::OUT_TUSER_W-1:0]    m_tuser
);
  import dpb_pkg::*;

  logic [DEPTH_W-1:0]  near_limit;
  logic [DEPTH_W-1:0]  far_limit;
  logic [CENTER_W-1:0] center [LANES];
  logic [INV_W-1:0]    inv    [LANES];

  cfg_reg_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = cfg_reg_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_limit <= NEAR_RST;
      far_limit  <= FAR_RST;
      center[0]  <= CCOL_RST;
      center[1]  <= CROW_RST;
      inv[0]     <= INVX_RST;
      inv[1]     <= INVY_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NEAR: near_limit <= pwdata[DEPTH_W-1:0];
        REG_FAR:  far_limit  <= pwdata[DEPTH_W-1:0];
        REG_CCOL: center[0]  <= pwdata[CENTER_W-1:0];
        REG_CROW: center[1]  <= pwdata[CENTER_W-1:0];
        REG_INVX: inv[0]     <= pwdata[INV_W-1:0];
        REG_INVY: inv[1]     <= pwdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_NEAR: prdata = APB_DATA_W'(near_limit);
      REG_FAR:  prdata = APB_DATA_W'(far_limit);
      REG_CCOL: prdata = APB_DATA_W'(center[0]);
      REG_CROW: prdata = APB_DATA_W'(center[1]);
      REG_INVX: prdata = APB_DATA_W'(inv[0]);
      REG_INVY: prdata = APB_DATA_W'(inv[1]);
      default:  prdata = '0;
    endcase
  end

  // input unpacking
  logic [DEPTH_W-1:0] in_depth;
  logic [PIX_W-1:0]   in_pix [LANES];
  logic               in_ok;

  assign in_depth  = s_tdata[15:0];
  assign in_pix[0] = s_tdata[27:16];
  assign in_pix[1] = s_tdata[39:28];
  assign in_ok     = (in_depth > near_limit) && (in_depth < far_limit) &&
                     ({1'b0, in_pix[0]} < DIM_W'(IMAGE_WIDTH)) &&
                     ({1'b0, in_pix[1]} < DIM_W'(IMAGE_HEIGHT));

  // stage control
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5      = !v5 || m_tready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // payload
  logic [DEPTH_W-1:0]  d1, d2, d3, d4, z5;
  logic                ok1, ok2, ok3, ok4, ok5;
  logic                neg1 [LANES];
  logic                neg2 [LANES];
  logic                neg3 [LANES];
  logic                neg4 [LANES];
  logic [DIFF_W-1:0]   magd1 [LANES];
  logic [PROD1_W-1:0]  prod2 [LANES];
  logic [PROD2_W-1:0]  prod3 [LANES];
  logic [MAG_W-1:0]    mag4  [LANES];
  logic [COORD_W-1:0]  coord5 [LANES];

  logic [CENTER_W-1:0] pix_q4 [LANES];
  logic [PROD2_W:0]    rnd    [LANES];
  logic [MAG_W-1:0]    clamp  [LANES];
  logic [COORD_W-1:0]  coord  [LANES];

  localparam logic [PROD2_W:0] HALF    = (PROD2_W+1)'(1) << (FRAC_BITS-1);
  localparam logic [MAG_W-1:0] NEG_MAX = MAG_W'(1) << (COORD_W-1);
  localparam logic [MAG_W-1:0] POS_MAX = NEG_MAX - MAG_W'(1);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      pix_q4[l] = {in_pix[l], 4'b0000};
      rnd[l]    = {1'b0, prod3[l]} + HALF;
      if (neg4[l]) begin
        clamp[l] = (mag4[l] > NEG_MAX) ? NEG_MAX : mag4[l];
        coord[l] = COORD_W'(0) - clamp[l][COORD_W-1:0];
      end else begin
        clamp[l] = (mag4[l] > POS_MAX) ? POS_MAX : mag4[l];
        coord[l] = clamp[l][COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      d1  <= in_depth;
      ok1 <= in_ok;
      for (int l = 0; l < LANES; l++) begin
        neg1[l]  <= pix_q4[l] < center[l];
        magd1[l] <= (pix_q4[l] < center[l]) ? center[l] - pix_q4[l]
                                            : pix_q4[l] - center[l];
      end
    end
    if (en2) begin
      d2  <= d1;
      ok2 <= ok1;
      for (int l = 0; l < LANES; l++) begin
        neg2[l]  <= neg1[l];
        prod2[l] <= PROD1_W'(magd1[l]) * PROD1_W'(d1);
      end
    end
    if (en3) begin
      d3  <= d2;
      ok3 <= ok2;
      for (int l = 0; l < LANES; l++) begin
        neg3[l]  <= neg2[l];
        prod3[l] <= PROD2_W'(prod2[l]) * PROD2_W'(inv[l]);
      end
    end
    if (en4) begin
      d4  <= d3;
      ok4 <= ok3;
      for (int l = 0; l < LANES; l++) begin
        neg4[l] <= neg3[l];
        mag4[l] <= rnd[l][PROD2_W:FRAC_BITS];
      end
    end
    if (en5) begin
      ok5 <= ok4;
      z5  <= ok4 ? d4 : '0;
      for (int l = 0; l < LANES; l++) begin
        coord5[l] <= ok4 ? coord[l] : '0;
      end
    end
  end

  assign m_tvalid = v5;
  assign m_tdata  = {z5, coord5[1], coord5[0]};
  assign m_tuser  = ok5;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid straight after reset");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && v3 && v4 && v5 && !m_tready))
    else $error("input stalled with a free stage");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("rejected point carries non-zero fields");

  a_valid_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |->
      (m_tdata[79:64] > near_limit && m_tdata[79:64] < far_limit))
    else $error("accepted point outside depth limits");
`endif

endmodule
